// ===== hw/rtl/sgrm_pkg.sv =====
// Shared types, op codes and sample constants for the stereo gain ring mixer.
package sgrm_pkg;

   localparam int SAMPLE_W    = 16;
   localparam int GAIN_W      = 8;
   localparam int FILL_W      = 14;
   localparam int QUEUE_DEPTH = 8;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam logic [1:0] OP_PUSH  = 2'd0;
   localparam logic [1:0] OP_MIX   = 2'd1;
   localparam logic [1:0] OP_FLUSH = 2'd2;

   localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 16'sh7FFF;
   localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = 16'sh8000;

   typedef struct packed {
      logic                       do_write;
      logic                       use_ring;
      logic [FILL_W-1:0]          fill_level;
      logic signed [SAMPLE_W-1:0] primary;
      logic signed [SAMPLE_W-1:0] left;
      logic signed [SAMPLE_W-1:0] right;
   } work_type;

   function automatic logic signed [SAMPLE_W-1:0] sat_sum(logic signed [SAMPLE_W:0] v);
      logic signed [SAMPLE_W-1:0] r;
      if (v > $signed({SAMPLE_MAX[SAMPLE_W-1], SAMPLE_MAX})) begin
         r = SAMPLE_MAX;
      end else if (v < $signed({SAMPLE_MIN[SAMPLE_W-1], SAMPLE_MIN})) begin
         r = SAMPLE_MIN;
      end else begin
         r = v[SAMPLE_W-1:0];
      end
      return r;
   endfunction

endpackage

// ===== hw/rtl/stereo_gain_ring_mixer.sv =====
// Top level of the stereo gain ring mixer: CSR, intake, work queue and ring back end.
//
// Requests enter on req_* (valid/stall); each op pushes a gain-scaled stereo
// pair into the ring, mixes the oldest ring entry into one primary sample, or
// flushes the ring. Every request yields exactly one response on rsp_*, in
// request order, carrying the mixed sample, the push acceptance flag and the
// ring fill level after the request.
// csr_write_enable/csr_write_data set mix_enable; write it only while idle.
// The accepting edge loads intake stage one (gain multiply); then come intake
// stage two (reciprocal divide), the queue slot, the ring read and the
// response register, in that order.
// Throughput: one request per cycle while req_stall and rsp_stall stay low. The ring
// is two banks of RING_DEPTH x 16 bits with one write and one read each per cycle,
// so a push stores both samples in the cycle it leaves the queue.
// An eight-entry queue separates intake and back end: while rsp_stall is high
// the response holds, the intake fills the queue, and req_stall rises once
// the queue plus the intake stages reach eight requests.
// Synchronous reset clears mix_enable, ring indices, queue and valids; ring
// contents are not cleared and there is no post-reset sweep.
module stereo_gain_ring_mixer import sgrm_pkg::*; #(
   parameter int RING_DEPTH      = 16384,
   parameter int GAIN_FULL_SCALE = 128
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic [1:0]                 req_op,
   input  logic signed [SAMPLE_W-1:0] req_left_in,
   input  logic signed [SAMPLE_W-1:0] req_right_in,
   input  logic [GAIN_W-1:0]          req_left_gain,
   input  logic [GAIN_W-1:0]          req_right_gain,
   input  logic signed [SAMPLE_W-1:0] req_primary_sample,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic signed [SAMPLE_W-1:0] rsp_mixed_sample,
   output logic                       rsp_accepted,
   output logic [FILL_W-1:0]          rsp_fill_level,
   input  logic                       csr_write_enable,
   input  logic                       csr_write_data
);

   localparam int PTR_W = $clog2(2 * RING_DEPTH);

   logic               mix_enable_ff;
   logic               q_push;
   work_type           q_work;
   logic [PTR_W-1:0]   q_ptr;
   logic [QCNT_W-1:0]  q_count;
   logic               head_valid;
   work_type           head_work;
   logic [PTR_W-1:0]   head_ptr;
   logic               pop;

   always_ff @(posedge clock) begin
      if (reset) begin
         mix_enable_ff <= 1'b0;
      end else if (csr_write_enable) begin
         mix_enable_ff <= csr_write_data;
      end
   end

   sgrm_front #(
      .RING_DEPTH      (RING_DEPTH),
      .GAIN_FULL_SCALE (GAIN_FULL_SCALE)
   ) u_front (
      .clock              (clock),
      .reset              (reset),
      .mix_enable         (mix_enable_ff),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_op             (req_op),
      .req_left_in        (req_left_in),
      .req_right_in       (req_right_in),
      .req_left_gain      (req_left_gain),
      .req_right_gain     (req_right_gain),
      .req_primary_sample (req_primary_sample),
      .q_count            (q_count),
      .q_push             (q_push),
      .q_work             (q_work),
      .q_ptr              (q_ptr)
   );

   sgrm_queue #(
      .PTR_W (PTR_W)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_work  (q_work),
      .push_ptr   (q_ptr),
      .pop        (pop),
      .head_valid (head_valid),
      .head_work  (head_work),
      .head_ptr   (head_ptr),
      .count      (q_count)
   );

   sgrm_back #(
      .RING_DEPTH (RING_DEPTH)
   ) u_back (
      .clock            (clock),
      .reset            (reset),
      .head_valid       (head_valid),
      .head_work        (head_work),
      .head_ptr         (head_ptr),
      .pop              (pop),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_mixed_sample (rsp_mixed_sample),
      .rsp_accepted     (rsp_accepted),
      .rsp_fill_level   (rsp_fill_level)
   );

   a_queue_room: assert property (@(posedge clock) disable iff (reset)
      q_push |-> (q_count < QCNT_W'(QUEUE_DEPTH)))
      else $error("work queue written while full");

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> (!rsp_valid && !req_stall))
      else $error("response or stall active after reset");

   a_push_no_sample: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_accepted) |-> (rsp_mixed_sample == '0))
      else $error("accepted push carries a mixed sample");

   a_pop_has_data: assert property (@(posedge clock) disable iff (reset)
      pop |-> head_valid)
      else $error("back end popped an empty queue");

endmodule

// ===== hw/rtl/sgrm_front.sv =====
// Request intake: ring index bookkeeping, push/mix classification and gain scaling pipeline.
module sgrm_front import sgrm_pkg::*; #(
   parameter int RING_DEPTH      = 16384,
   parameter int GAIN_FULL_SCALE = 128,
   localparam int PTR_W          = $clog2(2 * RING_DEPTH)
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       mix_enable,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic [1:0]                 req_op,
   input  logic signed [SAMPLE_W-1:0] req_left_in,
   input  logic signed [SAMPLE_W-1:0] req_right_in,
   input  logic [GAIN_W-1:0]          req_left_gain,
   input  logic [GAIN_W-1:0]          req_right_gain,
   input  logic signed [SAMPLE_W-1:0] req_primary_sample,
   input  logic [QCNT_W-1:0]          q_count,
   output logic                       q_push,
   output work_type                   q_work,
   output logic [PTR_W-1:0]           q_ptr
);

   localparam int PROD_W = SAMPLE_W + GAIN_W + 1;
   localparam int MAG_W  = SAMPLE_W + GAIN_W - 1;
   localparam int SHIFT  = MAG_W + $clog2(GAIN_FULL_SCALE);
   localparam int RCP_W  = MAG_W + 1;
   localparam int RP_W   = MAG_W + RCP_W;
   localparam longint unsigned RECIP_L =
      ((64'd1 << SHIFT) + GAIN_FULL_SCALE - 1) / GAIN_FULL_SCALE;
   localparam logic [RCP_W-1:0] RECIP = RECIP_L[RCP_W-1:0];
   localparam logic [PTR_W:0]   SPAN  = (PTR_W + 1)'(2 * RING_DEPTH);
   localparam logic [PTR_W-1:0] ROOM_LIMIT = PTR_W'(RING_DEPTH - 3);
   localparam logic [MAG_W-1:0] POS_LIMIT  = MAG_W'(32767);
   localparam logic [MAG_W-1:0] NEG_LIMIT  = MAG_W'(32768);

   function automatic logic [MAG_W-1:0] mag_of(logic signed [PROD_W-1:0] p);
      logic [PROD_W-1:0] a;
      a = p[PROD_W-1] ? PROD_W'(-p) : PROD_W'(p);
      return a[MAG_W-1:0];
   endfunction

   function automatic logic signed [SAMPLE_W-1:0] sat_quot(logic neg, logic [RP_W-1:0] rp);
      logic [RP_W-1:0]            sh;
      logic [MAG_W-1:0]           q;
      logic signed [SAMPLE_W-1:0] r;
      sh = rp >> SHIFT;
      q  = sh[MAG_W-1:0];
      if (!neg) begin
         r = (q > POS_LIMIT) ? SAMPLE_MAX : $signed(q[SAMPLE_W-1:0]);
      end else begin
         r = (q > NEG_LIMIT) ? SAMPLE_MIN : $signed(~q[SAMPLE_W-1:0] + 1'b1);
      end
      return r;
   endfunction

   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;

   logic                       s1_valid_ff;
   logic                       s1_do_write_ff, s1_do_write_in;
   logic                       s1_use_ring_ff, s1_use_ring_in;
   logic [PTR_W-1:0]           s1_fill_ff, s1_fill_in;
   logic signed [SAMPLE_W-1:0] s1_primary_ff, s1_primary_in;
   logic [PTR_W-1:0]           s1_ptr_ff, s1_ptr_in;
   logic signed [PROD_W-1:0]   s1_lprod_ff, s1_lprod_in;
   logic signed [PROD_W-1:0]   s1_rprod_ff, s1_rprod_in;

   logic                       s2_valid_ff;
   logic                       s2_do_write_ff;
   logic                       s2_use_ring_ff;
   logic [PTR_W-1:0]           s2_fill_ff;
   logic signed [SAMPLE_W-1:0] s2_primary_ff;
   logic [PTR_W-1:0]           s2_ptr_ff;
   logic                       s2_lneg_ff, s2_rneg_ff;
   logic [RP_W-1:0]            s2_lrec_ff, s2_lrec_in;
   logic [RP_W-1:0]            s2_rrec_ff, s2_rrec_in;

   logic [QCNT_W:0]            inflight;
   logic                       accept;
   logic [PTR_W:0]             w_ext, r_ext, diff, w_sum, r_sum;
   logic [PTR_W-1:0]           fill, w_plus2, r_plus1;
   logic [PTR_W+FILL_W-1:0]    fill_ext;

   assign inflight  = (QCNT_W + 1)'(q_count) + (QCNT_W + 1)'(s1_valid_ff)
                    + (QCNT_W + 1)'(s2_valid_ff);
   assign req_stall = inflight >= (QCNT_W + 1)'(QUEUE_DEPTH);
   assign accept    = req_valid && !req_stall;

   assign w_ext   = {1'b0, wr_ptr_ff};
   assign r_ext   = {1'b0, rd_ptr_ff};
   assign diff    = (w_ext >= r_ext) ? (w_ext - r_ext) : (w_ext + SPAN - r_ext);
   assign fill    = diff[PTR_W-1:0];
   assign w_sum   = w_ext + (PTR_W + 1)'(2);
   assign r_sum   = r_ext + (PTR_W + 1)'(1);
   assign w_plus2 = (w_sum >= SPAN) ? PTR_W'(w_sum - SPAN) : w_sum[PTR_W-1:0];
   assign r_plus1 = (r_sum >= SPAN) ? PTR_W'(r_sum - SPAN) : r_sum[PTR_W-1:0];

   always_comb begin
      wr_ptr_in      = wr_ptr_ff;
      rd_ptr_in      = rd_ptr_ff;
      s1_do_write_in = 1'b0;
      s1_use_ring_in = 1'b0;
      s1_fill_in     = fill;
      s1_primary_in  = '0;
      s1_ptr_in      = wr_ptr_ff;
      case (req_op)
         OP_PUSH: begin
            if (mix_enable && fill <= ROOM_LIMIT) begin
               s1_do_write_in = 1'b1;
               wr_ptr_in      = w_plus2;
               s1_fill_in     = fill + PTR_W'(2);
            end
         end
         OP_MIX: begin
            s1_primary_in = req_primary_sample;
            s1_ptr_in     = rd_ptr_ff;
            if (mix_enable && fill != '0) begin
               s1_use_ring_in = 1'b1;
               rd_ptr_in      = r_plus1;
               s1_fill_in     = fill - PTR_W'(1);
            end
         end
         OP_FLUSH: begin
            wr_ptr_in  = '0;
            rd_ptr_in  = '0;
            s1_fill_in = '0;
         end
         default: begin
         end
      endcase
      s1_lprod_in = $signed(req_left_in) * $signed({1'b0, req_left_gain});
      s1_rprod_in = $signed(req_right_in) * $signed({1'b0, req_right_gain});
      s2_lrec_in  = RP_W'(mag_of(s1_lprod_ff)) * RP_W'(RECIP);
      s2_rrec_in  = RP_W'(mag_of(s1_rprod_ff)) * RP_W'(RECIP);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff   <= '0;
         rd_ptr_ff   <= '0;
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            wr_ptr_ff <= wr_ptr_in;
            rd_ptr_ff <= rd_ptr_in;
         end
         s1_valid_ff <= accept;
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      s1_do_write_ff <= s1_do_write_in;
      s1_use_ring_ff <= s1_use_ring_in;
      s1_fill_ff     <= s1_fill_in;
      s1_primary_ff  <= s1_primary_in;
      s1_ptr_ff      <= s1_ptr_in;
      s1_lprod_ff    <= s1_lprod_in;
      s1_rprod_ff    <= s1_rprod_in;
      s2_do_write_ff <= s1_do_write_ff;
      s2_use_ring_ff <= s1_use_ring_ff;
      s2_fill_ff     <= s1_fill_ff;
      s2_primary_ff  <= s1_primary_ff;
      s2_ptr_ff      <= s1_ptr_ff;
      s2_lneg_ff     <= s1_lprod_ff[PROD_W-1];
      s2_rneg_ff     <= s1_rprod_ff[PROD_W-1];
      s2_lrec_ff     <= s2_lrec_in;
      s2_rrec_ff     <= s2_rrec_in;
   end

   assign fill_ext = {{FILL_W{1'b0}}, s2_fill_ff};

   always_comb begin
      q_push              = s2_valid_ff;
      q_ptr               = s2_ptr_ff;
      q_work.do_write     = s2_do_write_ff;
      q_work.use_ring     = s2_use_ring_ff;
      q_work.fill_level   = fill_ext[FILL_W-1:0];
      q_work.primary      = s2_primary_ff;
      q_work.left         = sat_quot(s2_lneg_ff, s2_lrec_ff);
      q_work.right        = sat_quot(s2_rneg_ff, s2_rrec_ff);
   end

endmodule

// ===== hw/rtl/sgrm_queue.sv =====
// Short FIFO of classified work between the intake and the ring back end.
module sgrm_queue import sgrm_pkg::*; #(
   parameter int PTR_W = 15
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  work_type           push_work,
   input  logic [PTR_W-1:0]   push_ptr,
   input  logic               pop,
   output logic               head_valid,
   output work_type           head_work,
   output logic [PTR_W-1:0]   head_ptr,
   output logic [QCNT_W-1:0]  count
);

   work_type           work_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]   ptr_ff  [QUEUE_DEPTH];
   logic [QPTR_W-1:0]  wr_idx_ff, wr_idx_in;
   logic [QPTR_W-1:0]  rd_idx_ff, rd_idx_in;
   logic [QCNT_W-1:0]  count_ff, count_in;
   logic               do_pop;

   assign do_pop     = pop && (count_ff != '0);
   assign head_valid = count_ff != '0;
   assign head_work  = work_ff[rd_idx_ff];
   assign head_ptr   = ptr_ff[rd_idx_ff];
   assign count      = count_ff;

   always_comb begin
      wr_idx_in = push ? QPTR_W'(wr_idx_ff + 1'b1) : wr_idx_ff;
      rd_idx_in = do_pop ? QPTR_W'(rd_idx_ff + 1'b1) : rd_idx_ff;
      count_in  = count_ff + QCNT_W'(push) - QCNT_W'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_idx_ff <= '0;
         rd_idx_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_idx_ff <= wr_idx_in;
         rd_idx_ff <= rd_idx_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         work_ff[wr_idx_ff] <= push_work;
         ptr_ff[wr_idx_ff]  <= push_ptr;
      end
   end

endmodule

// ===== hw/rtl/sgrm_back.sv =====
// Ring back end: two-bank sample store, mix add with saturation and response register.
module sgrm_back import sgrm_pkg::*; #(
   parameter int RING_DEPTH = 16384,
   localparam int PTR_W     = $clog2(2 * RING_DEPTH),
   localparam int ROW_W     = PTR_W - 1
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       head_valid,
   input  work_type                   head_work,
   input  logic [PTR_W-1:0]           head_ptr,
   output logic                       pop,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic signed [SAMPLE_W-1:0] rsp_mixed_sample,
   output logic                       rsp_accepted,
   output logic [FILL_W-1:0]          rsp_fill_level
);

   localparam logic [PTR_W:0] SPAN = (PTR_W + 1)'(2 * RING_DEPTH);

   logic [SAMPLE_W-1:0] bank0_mem [RING_DEPTH];
   logic [SAMPLE_W-1:0] bank1_mem [RING_DEPTH];

   logic [SAMPLE_W-1:0] rd0_ff, rd1_ff;
   logic                a_valid_ff, a_valid_in;
   work_type            a_work_ff;
   logic                a_sel_ff;
   logic                rsp_valid_ff, rsp_valid_in;
   logic signed [SAMPLE_W-1:0] rsp_mixed_ff, rsp_mixed_in;
   logic                rsp_accepted_ff;
   logic [FILL_W-1:0]   rsp_fill_ff;

   logic                a_adv;
   logic [PTR_W:0]      n_sum;
   logic [PTR_W-1:0]    next_ptr;
   logic [ROW_W-1:0]    row_a, row_b;
   logic                wr0_en, wr1_en;
   logic [ROW_W-1:0]    wr0_row, wr1_row;
   logic [SAMPLE_W-1:0] wr0_data, wr1_data;
   logic signed [SAMPLE_W-1:0] ring_val;

   assign a_adv    = a_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign pop      = head_valid && (!a_valid_ff || a_adv);
   assign n_sum    = {1'b0, head_ptr} + (PTR_W + 1)'(1);
   assign next_ptr = (n_sum >= SPAN) ? PTR_W'(n_sum - SPAN) : n_sum[PTR_W-1:0];
   assign row_a    = head_ptr[PTR_W-1:1];
   assign row_b    = next_ptr[PTR_W-1:1];

   always_comb begin
      wr0_en = pop && head_work.do_write;
      wr1_en = wr0_en;
      if (head_ptr[0]) begin
         wr1_row  = row_a;
         wr1_data = head_work.left;
         wr0_row  = row_b;
         wr0_data = head_work.right;
      end else begin
         wr0_row  = row_a;
         wr0_data = head_work.left;
         wr1_row  = row_b;
         wr1_data = head_work.right;
      end
   end

   always_ff @(posedge clock) begin
      if (wr0_en) begin
         bank0_mem[wr0_row] <= wr0_data;
      end
      if (pop) begin
         rd0_ff <= bank0_mem[row_a];
      end
   end

   always_ff @(posedge clock) begin
      if (wr1_en) begin
         bank1_mem[wr1_row] <= wr1_data;
      end
      if (pop) begin
         rd1_ff <= bank1_mem[row_a];
      end
   end

   always_comb begin
      a_valid_in = pop ? 1'b1 : (a_adv ? 1'b0 : a_valid_ff);
      if (a_adv) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
      ring_val     = $signed(a_sel_ff ? rd1_ff : rd0_ff);
      rsp_mixed_in = a_work_ff.use_ring
                   ? sat_sum({a_work_ff.primary[SAMPLE_W-1], a_work_ff.primary}
                             + {ring_val[SAMPLE_W-1], ring_val})
                   : a_work_ff.primary;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         a_valid_ff   <= a_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         a_work_ff <= head_work;
         a_sel_ff  <= head_ptr[0];
      end
      if (a_adv) begin
         rsp_mixed_ff    <= rsp_mixed_in;
         rsp_accepted_ff <= a_work_ff.do_write;
         rsp_fill_ff     <= a_work_ff.fill_level;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_mixed_sample = rsp_mixed_ff;
   assign rsp_accepted     = rsp_accepted_ff;
   assign rsp_fill_level   = rsp_fill_ff;

endmodule

// ===== tb/tb_stereo_gain_ring_mixer.sv =====
// Self-checking testbench for the stereo gain ring mixer: directed table and random traffic.
`timescale 1ns / 1ps

module tb_stereo_gain_ring_mixer import sgrm_pkg::*;;

   localparam int RING_DEPTH      = 16384;
   localparam int GAIN_FULL_SCALE = 128;
   localparam int HOLD_CYCLES     = 200;
   localparam int DRAIN_CYCLES    = 10;
   localparam int MAX_REPORTS     = 100;

   localparam logic [1:0] OP_SPARE = 2'd3;

   typedef struct packed {
      logic [1:0]                 op;
      logic signed [SAMPLE_W-1:0] left_in;
      logic signed [SAMPLE_W-1:0] right_in;
      logic [GAIN_W-1:0]          left_gain;
      logic [GAIN_W-1:0]          right_gain;
      logic signed [SAMPLE_W-1:0] primary;
   } mix_req_type;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] mixed;
      logic                       accepted;
      logic [FILL_W-1:0]          fill;
   } mix_rsp_type;

   typedef struct packed {
      logic        en;
      mix_req_type req;
      logic        typed;
      mix_rsp_type want;
   } scripted_req_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                       req_valid = 1'b0;
   logic                       req_stall;
   logic [1:0]                 req_op = OP_PUSH;
   logic signed [SAMPLE_W-1:0] req_left_in = '0;
   logic signed [SAMPLE_W-1:0] req_right_in = '0;
   logic [GAIN_W-1:0]          req_left_gain = '0;
   logic [GAIN_W-1:0]          req_right_gain = '0;
   logic signed [SAMPLE_W-1:0] req_primary_sample = '0;
   logic                       rsp_valid;
   logic                       rsp_stall = 1'b0;
   logic signed [SAMPLE_W-1:0] rsp_mixed_sample;
   logic                       rsp_accepted;
   logic [FILL_W-1:0]          rsp_fill_level;
   logic                       csr_write_enable = 1'b0;
   logic                       csr_write_data = 1'b0;

   stereo_gain_ring_mixer #(
      .RING_DEPTH      (RING_DEPTH),
      .GAIN_FULL_SCALE (GAIN_FULL_SCALE)
   ) u_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_op             (req_op),
      .req_left_in        (req_left_in),
      .req_right_in       (req_right_in),
      .req_left_gain      (req_left_gain),
      .req_right_gain     (req_right_gain),
      .req_primary_sample (req_primary_sample),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_mixed_sample   (rsp_mixed_sample),
      .rsp_accepted       (rsp_accepted),
      .rsp_fill_level     (rsp_fill_level),
      .csr_write_enable   (csr_write_enable),
      .csr_write_data     (csr_write_data)
   );

   always #5 clock = ~clock;

   // mixer state mirror
   logic signed [SAMPLE_W-1:0] ring_copy [RING_DEPTH];
   int   ring_wr = 0;
   int   ring_rd = 0;
   logic mix_on = 1'b0;

   scripted_req_type req_backlog[$];
   mix_rsp_type      mix_results_due[$];
   scripted_req_type on_port;
   logic             req_on_port = 1'b0;
   logic             req_idle_on = 1'b0;
   logic             rsp_idle_on = 1'b0;
   logic             rsp_hold_req = 1'b0;
   int               req_gap = 0;
   int               stall_run = 0;
   int               hold_count = 0;
   mix_rsp_type      due;
   mix_rsp_type      want;

   int mismatch_count = 0;
   int requests_taken = 0;
   int pairs_stored = 0;
   int pushes_refused = 0;
   int ring_mixes = 0;
   int peak_fill = 0;
   int input_held = 0;

   scripted_req_type directed_rows [27] = '{
      '{1'b0, '{OP_PUSH, SAMPLE_MAX, SAMPLE_MIN, 8'd255, 8'd255, 16'sd0},
        1'b1, '{16'sd0, 1'b0, 14'd0}},
      '{1'b0, '{OP_MIX, 16'sd0, 16'sd0, 8'd0, 8'd0, 16'sh1234},
        1'b1, '{16'sh1234, 1'b0, 14'd0}},
      '{1'b0, '{OP_FLUSH, 16'sd0, 16'sd0, 8'd0, 8'd0, 16'sd0},
        1'b1, '{16'sd0, 1'b0, 14'd0}},
      '{1'b0, '{OP_SPARE, 16'shFFFF, 16'shFFFF, 8'hFF, 8'hFF, 16'shFFFF},
        1'b1, '{16'sd0, 1'b0, 14'd0}},
      '{1'b1, '{OP_PUSH, SAMPLE_MAX, SAMPLE_MIN, 8'd255, 8'd255, 16'shFFFF},
        1'b1, '{16'sd0, 1'b1, 14'd2}},
      '{1'b1, '{OP_MIX, 16'sd0, 16'sd0, 8'd0, 8'd0, SAMPLE_MAX},
        1'b1, '{SAMPLE_MAX, 1'b0, 14'd1}},
      '{1'b1, '{OP_MIX, 16'sd0, 16'sd0, 8'd0, 8'd0, SAMPLE_MIN},
        1'b1, '{SAMPLE_MIN, 1'b0, 14'd0}},
      '{1'b1, '{OP_MIX, 16'sd0, 16'sd0, 8'd0, 8'd0, -16'sd5},
        1'b1, '{-16'sd5, 1'b0, 14'd0}},
      '{1'b1, '{OP_PUSH, -16'sd1, 16'sd1, 8'd1, 8'd1, 16'sd0},
        1'b1, '{16'sd0, 1'b1, 14'd2}},
      '{1'b1, '{OP_MIX, 16'sd0, 16'sd0, 8'd0, 8'd0, 16'sd100},
        1'b1, '{16'sd100, 1'b0, 14'd1}},
      '{1'b1, '{OP_MIX, 16'sd0, 16'sd0, 8'd0, 8'd0, -16'sd100},
        1'b1, '{-16'sd100, 1'b0, 14'd0}},
      '{1'b1, '{OP_PUSH, SAMPLE_MIN, SAMPLE_MAX, 8'd128, 8'd128, 16'sd0},
        1'b1, '{16'sd0, 1'b1, 14'd2}},
      '{1'b1, '{OP_MIX, 16'sd0, 16'sd0, 8'd0, 8'd0, 16'sd0},
        1'b1, '{SAMPLE_MIN, 1'b0, 14'd1}},
      '{1'b1, '{OP_MIX, 16'sd0, 16'sd0, 8'd0, 8'd0, 16'sd0},
        1'b1, '{SAMPLE_MAX, 1'b0, 14'd0}},
      '{1'b1, '{OP_PUSH, SAMPLE_MIN, 16'sd12345, 8'd0, 8'd200, 16'sd0},
        1'b0, '{16'sd0, 1'b0, 14'd0}},
      '{1'b1, '{OP_PUSH, -16'sd300, SAMPLE_MIN, 8'd129, 8'd129, 16'sd0},
        1'b0, '{16'sd0, 1'b0, 14'd0}},
      '{1'b1, '{OP_SPARE, 16'shFFFF, 16'shFFFF, 8'hFF, 8'hFF, 16'shFFFF},
        1'b1, '{16'sd0, 1'b0, 14'd4}},
      '{1'b1, '{OP_MIX, 16'sd0, 16'sd0, 8'd0, 8'd0, -16'sd1},
        1'b0, '{16'sd0, 1'b0, 14'd0}},
      '{1'b1, '{OP_MIX, 16'sd0, 16'sd0, 8'd0, 8'd0, 16'sh4000},
        1'b0, '{16'sd0, 1'b0, 14'd0}},
      '{1'b1, '{OP_FLUSH, 16'sd0, 16'sd0, 8'd0, 8'd0, 16'sd0},
        1'b1, '{16'sd0, 1'b0, 14'd0}},
      '{1'b1, '{OP_MIX, 16'sd0, 16'sd0, 8'd0, 8'd0, 16'sd7},
        1'b1, '{16'sd7, 1'b0, 14'd0}},
      '{1'b1, '{OP_PUSH, 16'sh5555, 16'shAAAA, 8'hAA, 8'h55, 16'sd0},
        1'b0, '{16'sd0, 1'b0, 14'd0}},
      '{1'b1, '{OP_PUSH, 16'sh2AAA, 16'shD555, 8'h55, 8'hAA, 16'sd0},
        1'b0, '{16'sd0, 1'b0, 14'd0}},
      '{1'b1, '{OP_MIX, 16'sd0, 16'sd0, 8'd0, 8'd0, 16'sh7000},
        1'b0, '{16'sd0, 1'b0, 14'd0}},
      '{1'b0, '{OP_MIX, 16'sd0, 16'sd0, 8'd0, 8'd0, 16'sd9},
        1'b1, '{16'sd9, 1'b0, 14'd3}},
      '{1'b0, '{OP_PUSH, 16'sd1000, 16'sd1000, 8'd128, 8'd128, 16'sd0},
        1'b1, '{16'sd0, 1'b0, 14'd3}},
      '{1'b0, '{OP_FLUSH, 16'sd0, 16'sd0, 8'd0, 8'd0, 16'sd0},
        1'b1, '{16'sd0, 1'b0, 14'd0}}
   };

   function automatic logic signed [SAMPLE_W-1:0] clamp16(int v);
      if (v > 32767) return SAMPLE_MAX;
      if (v < -32768) return SAMPLE_MIN;
      return SAMPLE_W'(v);
   endfunction

   function automatic int ring_fill();
      return (ring_wr - ring_rd + RING_DEPTH) % RING_DEPTH;
   endfunction

   function automatic mix_rsp_type predict_mix_result(mix_req_type r);
      mix_rsp_type o;
      int          fill;
      o = '0;
      fill = ring_fill();
      case (r.op)
         OP_PUSH: begin
            if (mix_on && RING_DEPTH - fill - 1 >= 2) begin
               ring_copy[ring_wr] = clamp16(int'($signed(r.left_in)) * int'(r.left_gain)
                                            / GAIN_FULL_SCALE);
               ring_wr = (ring_wr + 1) % RING_DEPTH;
               ring_copy[ring_wr] = clamp16(int'($signed(r.right_in)) * int'(r.right_gain)
                                            / GAIN_FULL_SCALE);
               ring_wr = (ring_wr + 1) % RING_DEPTH;
               o.accepted = 1'b1;
               pairs_stored++;
            end else begin
               pushes_refused++;
            end
         end
         OP_MIX: begin
            o.mixed = r.primary;
            if (mix_on && fill != 0) begin
               o.mixed = clamp16(int'($signed(r.primary)) + int'(ring_copy[ring_rd]));
               ring_rd = (ring_rd + 1) % RING_DEPTH;
               ring_mixes++;
            end
         end
         OP_FLUSH: begin
            ring_wr = 0;
            ring_rd = 0;
         end
         default: ;
      endcase
      fill = ring_fill();
      o.fill = FILL_W'(fill);
      if (fill > peak_fill) peak_fill = fill;
      return o;
   endfunction

   function automatic int pick_gap();
      if ($urandom_range(0, 15) == 0) return int'($urandom_range(10, 30));
      return int'($urandom_range(1, 3));
   endfunction

   function automatic logic signed [SAMPLE_W-1:0] pick_sample();
      int v;
      case ($urandom_range(0, 7))
         0: return SAMPLE_MAX;
         1: return SAMPLE_MIN;
         2: begin
            v = int'($urandom_range(0, 600)) - 300;
            return SAMPLE_W'(v);
         end
         default: return SAMPLE_W'($urandom);
      endcase
   endfunction

   function automatic logic [GAIN_W-1:0] pick_gain();
      case ($urandom_range(0, 7))
         0: return '0;
         1: return '1;
         2: return GAIN_W'(GAIN_FULL_SCALE);
         default: return GAIN_W'($urandom);
      endcase
   endfunction

   function automatic mix_req_type random_request();
      mix_req_type r;
      int          pick;
      pick = $urandom_range(0, 39);
      if (pick < 18) r.op = OP_PUSH;
      else if (pick < 37) r.op = OP_MIX;
      else if (pick < 39) r.op = OP_FLUSH;
      else r.op = OP_SPARE;
      r.left_in = pick_sample();
      r.right_in = pick_sample();
      r.left_gain = pick_gain();
      r.right_gain = pick_gain();
      r.primary = pick_sample();
      return r;
   endfunction

   task automatic queue_op(logic [1:0] op);
      mix_req_type r;
      r = random_request();
      r.op = op;
      req_backlog.push_back('{1'b0, r, 1'b0, '0});
   endtask

   task automatic queue_random(int count);
      repeat (count) req_backlog.push_back('{1'b0, random_request(), 1'b0, '0});
   endtask

   task automatic wait_idle();
      @(posedge clock);
      while (req_backlog.size() != 0 || req_on_port) @(posedge clock);
      while (mix_results_due.size() != 0) @(posedge clock);
   endtask

   task automatic set_mix_enable(logic v);
      wait_idle();
      csr_write_enable <= 1'b1;
      csr_write_data <= v;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      mix_on = v;
   endtask

   // request side: present backlog, predict on acceptance
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            due = predict_mix_result(on_port.req);
            if (on_port.typed) due = on_port.want;
            mix_results_due.push_back(due);
            req_on_port = 1'b0;
            requests_taken++;
         end
         if (req_valid && req_stall) input_held++;
         if (!req_on_port) begin
            if (req_gap > 0) begin
               req_gap--;
               req_valid <= 1'b0;
            end else if (req_backlog.size() != 0) begin
               on_port = req_backlog.pop_front();
               req_op <= on_port.req.op;
               req_left_in <= on_port.req.left_in;
               req_right_in <= on_port.req.right_in;
               req_left_gain <= on_port.req.left_gain;
               req_right_gain <= on_port.req.right_gain;
               req_primary_sample <= on_port.req.primary;
               req_valid <= 1'b1;
               req_on_port = 1'b1;
               req_gap = (req_idle_on && $urandom_range(0, 2) == 0) ? pick_gap() : 0;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // response side: random stalls, or a long hold on request
   always @(posedge clock) begin
      if (rsp_hold_req) begin
         rsp_stall <= 1'b1;
         hold_count++;
         if (hold_count >= HOLD_CYCLES) begin
            rsp_hold_req = 1'b0;
            hold_count = 0;
         end
      end else begin
         if (stall_run == 0 && rsp_idle_on && $urandom_range(0, 3) == 0) stall_run = pick_gap();
         rsp_stall <= (stall_run != 0);
         if (stall_run != 0) stall_run--;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (mix_results_due.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS) $error("response with no request outstanding");
         end else begin
            want = mix_results_due.pop_front();
            if (rsp_mixed_sample !== want.mixed) begin
               mismatch_count++;
               if (mismatch_count <= MAX_REPORTS)
                  $error("mixed_sample expected %0d actual %0d", want.mixed, rsp_mixed_sample);
            end
            if (rsp_accepted !== want.accepted) begin
               mismatch_count++;
               if (mismatch_count <= MAX_REPORTS)
                  $error("accepted expected %0d actual %0d", want.accepted, rsp_accepted);
            end
            if (rsp_fill_level !== want.fill) begin
               mismatch_count++;
               if (mismatch_count <= MAX_REPORTS)
                  $error("fill_level expected %0d actual %0d", want.fill, rsp_fill_level);
            end
         end
      end
   end

   initial begin
      #10ms;
      $error("timeout with %0d responses outstanding", mix_results_due.size());
      $display("== FAIL ==");
      $finish;
   end

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      req_idle_on = 1'b1;
      rsp_idle_on = 1'b1;

      foreach (directed_rows[k]) begin
         if (directed_rows[k].en != mix_on) set_mix_enable(directed_rows[k].en);
         req_backlog.push_back(directed_rows[k]);
      end

      // hold the response side while requests keep coming
      set_mix_enable(1'b1);
      req_idle_on = 1'b0;
      rsp_hold_req = 1'b1;
      queue_random(60);
      wait_idle();

      // build up a deep ring, drain part of it, then check the disabled paths
      rsp_idle_on = 1'b0;
      queue_op(OP_FLUSH);
      repeat (300) queue_op(OP_PUSH);
      repeat (200) queue_op(OP_MIX);
      set_mix_enable(1'b0);
      repeat (5) queue_op(OP_MIX);
      repeat (5) queue_op(OP_PUSH);
      set_mix_enable(1'b1);
      queue_random(50);
      queue_op(OP_FLUSH);

      for (int ph = 0; ph < 6; ph++) begin
         set_mix_enable(ph != 3);
         req_idle_on = (ph != 2);
         rsp_idle_on = (ph != 2);
         queue_random(150);
      end

      wait_idle();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mix_results_due.size() != 0) begin
         $error("%0d expected responses never arrived", mix_results_due.size());
         mismatch_count++;
      end
      $display("Covered %0d requests: %0d pairs stored, %0d pushes refused, %0d ring mixes,",
               requests_taken, pairs_stored, pushes_refused, ring_mixes);
      $display("peak ring fill %0d, input stalled with a request waiting for %0d cycles.",
               peak_fill, input_held);
      if (mismatch_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
